// ===== sv/jtd_pkg.sv =====
package jtd_pkg;

  // Default width of one assembled shift word
  localparam int unsigned ByteBits = 8;

  // Configuration reset values
  localparam logic [7:0] ProgramOpcodeRst = 8'h71;
  localparam logic [3:0] AddressCountRst  = 4'd4;

  // Depth of the queue between decode and output
  localparam int unsigned QueueDepth = 2;

  // Configuration register indexes
  typedef enum logic {
    CFG_PROGRAM_OPCODE = 1'b0,
    CFG_ADDRESS_COUNT  = 1'b1
  } cfg_idx_e;

  // Result item kinds
  typedef enum logic [1:0] {
    KIND_IR   = 2'd0,
    KIND_DR   = 2'd1,
    KIND_DROP = 2'd2
  } kind_e;

  // TAP controller states, one-hot; bit position is the state number
  typedef enum logic [15:0] {
    TAP_RESET      = 16'h0001,
    TAP_IDLE       = 16'h0002,
    TAP_SELECT_DR  = 16'h0004,
    TAP_CAPTURE_DR = 16'h0008,
    TAP_SHIFT_DR   = 16'h0010,
    TAP_EXIT1_DR   = 16'h0020,
    TAP_PAUSE_DR   = 16'h0040,
    TAP_EXIT2_DR   = 16'h0080,
    TAP_UPDATE_DR  = 16'h0100,
    TAP_SELECT_IR  = 16'h0200,
    TAP_CAPTURE_IR = 16'h0400,
    TAP_SHIFT_IR   = 16'h0800,
    TAP_EXIT1_IR   = 16'h1000,
    TAP_PAUSE_IR   = 16'h2000,
    TAP_EXIT2_IR   = 16'h4000,
    TAP_UPDATE_IR  = 16'h8000
  } tap_e;

  // One decoded result on its way to the output
  typedef struct packed {
    kind_e      kind;
    logic [7:0] tdi_byte;
    logic [7:0] tdo_byte;
    logic       is_address;
    logic       starts_group;
    logic [2:0] partial_bits;
    logic [3:0] tap_now;
  } jtd_rec_t;

  // Standard TAP transition on TMS
  function automatic tap_e tap_next(tap_e s, logic tms);
    tap_e n;
    case (s)
      TAP_RESET:      n = tms ? TAP_RESET     : TAP_IDLE;
      TAP_IDLE:       n = tms ? TAP_SELECT_DR : TAP_IDLE;
      TAP_SELECT_DR:  n = tms ? TAP_SELECT_IR : TAP_CAPTURE_DR;
      TAP_CAPTURE_DR: n = tms ? TAP_EXIT1_DR  : TAP_SHIFT_DR;
      TAP_SHIFT_DR:   n = tms ? TAP_EXIT1_DR  : TAP_SHIFT_DR;
      TAP_EXIT1_DR:   n = tms ? TAP_UPDATE_DR : TAP_PAUSE_DR;
      TAP_PAUSE_DR:   n = tms ? TAP_EXIT2_DR  : TAP_PAUSE_DR;
      TAP_EXIT2_DR:   n = tms ? TAP_UPDATE_DR : TAP_SHIFT_DR;
      TAP_UPDATE_DR:  n = tms ? TAP_SELECT_DR : TAP_IDLE;
      TAP_SELECT_IR:  n = tms ? TAP_RESET     : TAP_CAPTURE_IR;
      TAP_CAPTURE_IR: n = tms ? TAP_EXIT1_IR  : TAP_SHIFT_IR;
      TAP_SHIFT_IR:   n = tms ? TAP_EXIT1_IR  : TAP_SHIFT_IR;
      TAP_EXIT1_IR:   n = tms ? TAP_UPDATE_IR : TAP_PAUSE_IR;
      TAP_PAUSE_IR:   n = tms ? TAP_EXIT2_IR  : TAP_PAUSE_IR;
      TAP_EXIT2_IR:   n = tms ? TAP_UPDATE_IR : TAP_SHIFT_IR;
      TAP_UPDATE_IR:  n = tms ? TAP_SELECT_DR : TAP_IDLE;
      default:        n = TAP_RESET;
    endcase
    return n;
  endfunction

  // One-hot state to its state number
  function automatic logic [3:0] tap_index(tap_e s);
    logic [15:0] v;
    logic [3:0]  idx;
    v   = s;
    idx = '0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) begin
        idx = idx | 4'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== sv/jtd_in_if.sv =====
interface jtd_in_if;
  logic valid;
  logic ready;
  logic tck;
  logic tms;
  logic tdi;
  logic tdo;

  modport source (output valid, output tck, output tms, output tdi, output tdo,
                  input ready);
  modport sink   (input valid, input tck, input tms, input tdi, input tdo,
                  output ready);
endinterface

// ===== sv/jtd_out_if.sv =====
interface jtd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] tdi_byte;
  logic [7:0] tdo_byte;
  logic       is_address;
  logic       starts_group;
  logic [2:0] partial_bits;
  logic [3:0] tap_now;

  modport source (output valid, output kind, output tdi_byte, output tdo_byte,
                  output is_address, output starts_group, output partial_bits,
                  output tap_now, input ready);
  modport sink   (input valid, input kind, input tdi_byte, input tdo_byte,
                  input is_address, input starts_group, input partial_bits,
                  input tap_now, output ready);
endinterface

// ===== sv/jtd_front.sv =====
module jtd_front
  import jtd_pkg::*;
#(
  parameter int unsigned BYTE_BITS = ByteBits
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  jtd_in_if.sink   in_i,
  input  logic     cfg_we_i,
  input  cfg_idx_e cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic     q_full_i,
  output logic     push_o,
  output jtd_rec_t rec_o
);

  localparam int unsigned IdxW = (BYTE_BITS > 1) ? $clog2(BYTE_BITS) : 1;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(BYTE_BITS - 1);

  logic [7:0] opcode_q, opcode_d;
  logic [3:0] addr_cnt_q, addr_cnt_d;

  logic prev_tck_q, prev_tck_d;
  tap_e tap_q, tap_d;
  logic [BYTE_BITS-1:0] ir_tdi_q, ir_tdi_d, ir_tdo_q, ir_tdo_d;
  logic [BYTE_BITS-1:0] dr_tdi_q, dr_tdi_d, dr_tdo_q, dr_tdo_d;
  logic [IdxW-1:0] ir_idx_q, ir_idx_d, dr_idx_q, dr_idx_d;
  logic addr_pend_q, addr_pend_d;
  logic [3:0] addr_seen_q, addr_seen_d;
  logic dr_since_q, dr_since_d;

  logic accept;
  logic tck_rise;
  tap_e nxt;
  logic leaving;
  logic [3:0] seen_inc;
  logic [IdxW:0] ir_cnt, dr_cnt;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;
  assign tck_rise   = !prev_tck_q && in_i.tck;
  assign nxt        = tap_next(tap_q, in_i.tms);
  assign leaving    = ((tap_q == TAP_SHIFT_IR) || (tap_q == TAP_SHIFT_DR)) && (nxt != tap_q);
  assign seen_inc   = addr_seen_q + 4'd1;
  assign ir_cnt     = {1'b0, ir_idx_q} + (IdxW+1)'(1);
  assign dr_cnt     = {1'b0, dr_idx_q} + (IdxW+1)'(1);

  // Configuration writes
  always_comb begin
    opcode_d   = opcode_q;
    addr_cnt_d = addr_cnt_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PROGRAM_OPCODE: opcode_d   = cfg_data_i;
        CFG_ADDRESS_COUNT:  addr_cnt_d = cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Decode one sample: shift, complete bytes, step TAP, drop partials
  always_comb begin
    prev_tck_d  = prev_tck_q;
    tap_d       = tap_q;
    ir_tdi_d    = ir_tdi_q;
    ir_tdo_d    = ir_tdo_q;
    ir_idx_d    = ir_idx_q;
    dr_tdi_d    = dr_tdi_q;
    dr_tdo_d    = dr_tdo_q;
    dr_idx_d    = dr_idx_q;
    addr_pend_d = addr_pend_q;
    addr_seen_d = addr_seen_q;
    dr_since_d  = dr_since_q;
    push_o      = 1'b0;
    rec_o       = '0;
    rec_o.kind  = KIND_IR;
    rec_o.tap_now = tap_index(nxt);

    if (accept) begin
      prev_tck_d = in_i.tck;
      if (tck_rise) begin
        tap_d = nxt;

        if (tap_q == TAP_SHIFT_IR) begin
          ir_tdi_d = ir_tdi_q | (BYTE_BITS'(in_i.tdi) << ir_idx_q);
          ir_tdo_d = ir_tdo_q | (BYTE_BITS'(in_i.tdo) << ir_idx_q);
          if (ir_idx_q == IdxLast) begin
            push_o             = 1'b1;
            rec_o.kind         = KIND_IR;
            rec_o.tdi_byte     = 8'(ir_tdi_d);
            rec_o.tdo_byte     = 8'(ir_tdo_d);
            rec_o.starts_group = dr_since_q;
            dr_since_d         = 1'b0;
            if ((8'(ir_tdi_d) == opcode_q) && (addr_cnt_q != 4'd0)) begin
              addr_pend_d = 1'b1;
            end
            ir_tdi_d = '0;
            ir_tdo_d = '0;
            ir_idx_d = '0;
          end else begin
            ir_idx_d = IdxW'(ir_cnt);
          end
        end else if (tap_q == TAP_SHIFT_DR) begin
          dr_tdi_d = dr_tdi_q | (BYTE_BITS'(in_i.tdi) << dr_idx_q);
          dr_tdo_d = dr_tdo_q | (BYTE_BITS'(in_i.tdo) << dr_idx_q);
          if (dr_idx_q == IdxLast) begin
            push_o           = 1'b1;
            rec_o.kind       = KIND_DR;
            rec_o.tdi_byte   = 8'(dr_tdi_d);
            rec_o.tdo_byte   = 8'(dr_tdo_d);
            rec_o.is_address = addr_pend_q;
            if (addr_pend_q) begin
              if (seen_inc == addr_cnt_q) begin
                addr_pend_d = 1'b0;
                addr_seen_d = 4'd0;
              end else begin
                addr_seen_d = seen_inc;
              end
            end
            dr_since_d = 1'b1;
            dr_tdi_d   = '0;
            dr_tdo_d   = '0;
            dr_idx_d   = '0;
          end else begin
            dr_idx_d = IdxW'(dr_cnt);
          end
        end

        // Leaving a shift state: report and clear a partial word
        if (leaving) begin
          if (dr_idx_d != '0) begin
            if (!push_o) begin
              push_o             = 1'b1;
              rec_o.kind         = KIND_DROP;
              rec_o.tdi_byte     = 8'(dr_tdi_d);
              rec_o.tdo_byte     = 8'(dr_tdo_d);
              rec_o.partial_bits = 3'(dr_idx_d);
            end
            dr_idx_d = '0;
            dr_tdi_d = '0;
            dr_tdo_d = '0;
          end
          if (ir_idx_d != '0) begin
            if (!push_o) begin
              push_o             = 1'b1;
              rec_o.kind         = KIND_DROP;
              rec_o.tdi_byte     = 8'(ir_tdi_d);
              rec_o.tdo_byte     = 8'(ir_tdo_d);
              rec_o.partial_bits = 3'(ir_idx_d);
            end
            ir_idx_d = '0;
            ir_tdi_d = '0;
            ir_tdo_d = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opcode_q    <= ProgramOpcodeRst;
      addr_cnt_q  <= AddressCountRst;
      prev_tck_q  <= 1'b0;
      tap_q       <= TAP_RESET;
      ir_tdi_q    <= '0;
      ir_tdo_q    <= '0;
      ir_idx_q    <= '0;
      dr_tdi_q    <= '0;
      dr_tdo_q    <= '0;
      dr_idx_q    <= '0;
      addr_pend_q <= 1'b0;
      addr_seen_q <= 4'd0;
      dr_since_q  <= 1'b0;
    end else begin
      opcode_q    <= opcode_d;
      addr_cnt_q  <= addr_cnt_d;
      prev_tck_q  <= prev_tck_d;
      tap_q       <= tap_d;
      ir_tdi_q    <= ir_tdi_d;
      ir_tdo_q    <= ir_tdo_d;
      ir_idx_q    <= ir_idx_d;
      dr_tdi_q    <= dr_tdi_d;
      dr_tdo_q    <= dr_tdo_d;
      dr_idx_q    <= dr_idx_d;
      addr_pend_q <= addr_pend_d;
      addr_seen_q <= addr_seen_d;
      dr_since_q  <= dr_since_d;
    end
  end

endmodule

// ===== sv/jtd_queue.sv =====
module jtd_queue
  import jtd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  jtd_rec_t rec_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output jtd_rec_t rec_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);

  jtd_rec_t mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule

// ===== sv/jtd_back.sv =====
module jtd_back
  import jtd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  jtd_rec_t  q_rec_i,
  output logic      pop_o,
  jtd_out_if.source out_o
);

  logic     out_valid_q, out_valid_d;
  jtd_rec_t out_rec_q;

  // Refill the output register when it is empty or being taken
  assign pop_o = q_valid_i && (!out_valid_q || out_o.ready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_rec_q <= q_rec_i;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = out_rec_q.kind;
  assign out_o.tdi_byte     = out_rec_q.tdi_byte;
  assign out_o.tdo_byte     = out_rec_q.tdo_byte;
  assign out_o.is_address   = out_rec_q.is_address;
  assign out_o.starts_group = out_rec_q.starts_group;
  assign out_o.partial_bits = out_rec_q.partial_bits;
  assign out_o.tap_now      = out_rec_q.tap_now;

endmodule

// ===== sv/jtag_trace_decoder.sv =====
// JTAG trace decoder: one line sample accepted per cycle, sustained while the queue is not full.
// A result item passes from the sample decode into a two-entry queue, and from there
// into the output register that presents it.
// The queue decouples decode from output stalls; input stalls only when it is full.
// Reset (rst_ni, asynchronous, active low): TAP in Test-Logic-Reset, shift words
// and counters cleared, program opcode 0x71, address byte count 4.
module jtag_trace_decoder
  import jtd_pkg::*;
#(
  parameter int unsigned BYTE_BITS = ByteBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  jtd_in_if.sink    in_i,
  jtd_out_if.source out_o,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic [7:0] cfg_data_i
);

  logic     q_full;
  logic     push;
  jtd_rec_t push_rec;
  logic     pop;
  logic     q_valid;
  jtd_rec_t q_rec;

  // Sample decode and TAP tracking
  jtd_front #(
    .BYTE_BITS(BYTE_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_e'(cfg_idx_i)),
    .cfg_data_i(cfg_data_i),
    .q_full_i  (q_full),
    .push_o    (push),
    .rec_o     (push_rec)
  );

  // Result queue
  jtd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (push_rec),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .rec_o  (q_rec)
  );

  // Output register
  jtd_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_rec_i  (q_rec),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule
